### src/integer_to_english_word_tokens_core_assert.svh
// Assertion macros shared by the word token core.
// No dependencies; included by the top-level module, which carries the checks.
`ifndef INTEGER_TO_ENGLISH_WORD_TOKENS_CORE_ASSERT_SVH
`define INTEGER_TO_ENGLISH_WORD_TOKENS_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define I2E_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("i2e check failed");
`define I2E_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("i2e check failed");
`else
`define I2E_ASSERT(lbl, clk, rst, prop)
`define I2E_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### src/i2e_pkg.sv
// Shared types and constants for the integer to English word token core.
// No dependencies.
package i2e_pkg;

   localparam int VALUE_W    = 31;
   localparam int WORD_W     = 5;
   localparam int DIGIT_W    = 4;
   localparam int NUM_DIGITS = 10;
   localparam int CNT_W      = $clog2(VALUE_W);
   localparam int GRP_W      = 2;

   localparam logic [WORD_W-1:0] WORD_ZERO      = 5'd0;
   localparam logic [WORD_W-1:0] WORD_TEN       = 5'd10;
   localparam logic [WORD_W-1:0] WORD_TENS_BASE = 5'd20;
   localparam logic [WORD_W-1:0] WORD_HUNDRED   = 5'd28;
   localparam logic [WORD_W-1:0] WORD_THOUSAND  = 5'd29;

   typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_digits_type;

   typedef struct packed {
      logic busy;
      logic done;
   } bcd_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CONV,
      S_HUND,
      S_HWORD,
      S_REST,
      S_UNIT,
      S_TIER,
      S_FLUSH
   } state_type;

   function automatic logic bcd_ok(input bcd_digits_type d);
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (d[i] > 4'd9) ok = 1'b0;
      end
      return ok;
   endfunction

endpackage

### src/i2e_bcd.sv
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
// Depends on i2e_pkg.
module i2e_bcd import i2e_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [VALUE_W-1:0]  value,
   output bcd_status_type      status,
   output bcd_digits_type      digits
);

   logic [VALUE_W-1:0] bin_ff, bin_in;
   bcd_digits_type     dig_ff, dig_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   bcd_digits_type     adj;

   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         adj[i] = (dig_ff[i] >= 4'd5) ? dig_ff[i] + 4'd3 : dig_ff[i];
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      dig_in  = dig_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start && !busy_ff) begin
         bin_in  = value;
         dig_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bin_in    = {bin_ff[VALUE_W-2:0], 1'b0};
         dig_in[0] = {adj[0][DIGIT_W-2:0], bin_ff[VALUE_W-1]};
         for (int i = 1; i < NUM_DIGITS; i++) begin
            dig_in[i] = {adj[i][DIGIT_W-2:0], adj[i-1][DIGIT_W-1]};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(VALUE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      dig_ff <= dig_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign digits      = dig_ff;

endmodule

### src/integer_to_english_word_tokens_core.sv
// Integer to English word tokens: top level.
// After accept the value goes through bit-serial BCD conversion, then one sequencer step per
// cycle while the output register is free, until the final word reaches the output register.
// One value at a time: a new value is taken only once the previous one has been flushed;
// each stalled output beat holds the sequencer. Sync active-high reset clears control state.
// Depends on i2e_pkg, i2e_bcd and integer_to_english_word_tokens_core_assert.svh.
`include "integer_to_english_word_tokens_core_assert.svh"
module integer_to_english_word_tokens_core import i2e_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [VALUE_W-1:0]  req_value,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [WORD_W-1:0]   rsp_word_code,
   output logic                rsp_last_word
);

   // converter
   bcd_status_type bcd_status;
   bcd_digits_type bcd_digits;
   logic           bcd_start;

   // sequencer state
   state_type          state_ff, state_in;
   logic [GRP_W-1:0]   grp_ff, grp_in;

   // pending word: held back until the next word or the flush, so the final one can carry the last flag
   logic [WORD_W-1:0]  pend_ff, pend_in;
   logic               pend_valid_ff, pend_valid_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_word_ff, rsp_word_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               out_free;
   logic               emit;
   logic [WORD_W-1:0]  emit_code;
   logic [DIGIT_W-1:0] hd, td, ud;

   i2e_bcd u_bcd (
      .clock  (clock),
      .reset  (reset),
      .start  (bcd_start),
      .value  (req_value),
      .status (bcd_status),
      .digits (bcd_digits)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign bcd_start = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // digits of the current base-1000 group; the billions group has one digit
   always_comb begin
      case (grp_ff)
         2'd3: begin
            hd = '0;            td = '0;            ud = bcd_digits[9];
         end
         2'd2: begin
            hd = bcd_digits[8]; td = bcd_digits[7]; ud = bcd_digits[6];
         end
         2'd1: begin
            hd = bcd_digits[5]; td = bcd_digits[4]; ud = bcd_digits[3];
         end
         default: begin
            hd = bcd_digits[2]; td = bcd_digits[1]; ud = bcd_digits[0];
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      grp_in        = grp_ff;
      emit          = 1'b0;
      emit_code     = WORD_ZERO;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_word_in   = rsp_word_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (bcd_start) state_in = S_CONV;
         end
         S_CONV: begin
            if (bcd_status.done) begin
               state_in = S_HUND;
               grp_in   = 2'd3;
            end
         end
         S_HUND: begin
            if (out_free) begin
               if (hd == '0 && td == '0 && ud == '0) begin
                  // empty group: nothing spoken, not even the tier word
                  if (grp_ff == '0) state_in = S_FLUSH;
                  else grp_in = grp_ff - 1'b1;
               end else if (hd != '0) begin
                  emit      = 1'b1;
                  emit_code = {1'b0, hd};
                  state_in  = S_HWORD;
               end else begin
                  state_in = S_REST;
               end
            end
         end
         S_HWORD: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_code = WORD_HUNDRED;
               state_in  = S_REST;
            end
         end
         S_REST: begin
            if (out_free) begin
               state_in = S_TIER;
               if (td == '0) begin
                  if (ud != '0) begin
                     emit      = 1'b1;
                     emit_code = {1'b0, ud};
                  end
               end else if (td == 4'd1) begin
                  // teens
                  emit      = 1'b1;
                  emit_code = WORD_TEN + {1'b0, ud};
               end else begin
                  emit      = 1'b1;
                  emit_code = WORD_TENS_BASE + {1'b0, td} - 5'd2;
                  if (ud != '0) state_in = S_UNIT;
               end
            end
         end
         S_UNIT: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_code = {1'b0, ud};
               state_in  = S_TIER;
            end
         end
         S_TIER: begin
            if (out_free) begin
               if (grp_ff == '0) begin
                  state_in = S_FLUSH;
               end else begin
                  emit      = 1'b1;
                  emit_code = WORD_HUNDRED + {3'b0, grp_ff};
                  grp_in    = grp_ff - 1'b1;
                  state_in  = S_HUND;
               end
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               // nothing pending means the value was zero
               rsp_valid_in  = 1'b1;
               rsp_word_in   = pend_valid_ff ? pend_ff : WORD_ZERO;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a new word pushes the pending one out; out_free already checked
      if (emit) begin
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_word_in  = pend_ff;
            rsp_last_in  = 1'b0;
         end
         pend_in       = emit_code;
         pend_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff      <= grp_in;
      pend_ff     <= pend_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_word_code = rsp_word_ff;
   assign rsp_last_word = rsp_last_ff;

   // checks
   `I2E_ASSERT(a_accept_starts_conv, clock, reset, bcd_start |=> state_ff == S_CONV)
   `I2E_ASSERT(a_bcd_digits_ok, clock, reset, bcd_status.done |-> bcd_ok(bcd_digits))
   `I2E_ASSERT(a_zero_is_last, clock, reset, rsp_valid_ff && rsp_word_ff == WORD_ZERO |-> rsp_last_ff)
   `I2E_ASSERT(a_tier_word, clock, reset, state_ff == S_TIER && grp_ff != '0 && out_free |=> pend_ff >= WORD_THOUSAND)

endmodule
